// ----- hw/rtl/lss_pkg.sv -----
// Package for lidar_sector_steering: word types, configuration register
// indexes, command codes, scan geometry and the left-sector sine table.
// No dependencies.
`default_nettype none

package lss_pkg;

    localparam int SCAN_POINTS = 1000;
    localparam int LEFT_END    = 208;
    localparam int RIGHT_AFTER = 791;

    localparam int IDX_W   = 10;
    localparam int RANGE_W = 16;
    localparam int SINE_W  = 17;
    localparam int LPOS_W  = $clog2(LEFT_END);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE_SPEED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_LIMIT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_JUMP_LIMIT   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_LIMIT  = 2'd3;

    localparam logic [1:0] CMD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_RIGHT = 2'd2;

    localparam logic [18:0] STOP_SPEED_Q8 = 19'd384000;
    localparam logic [15:0] STOP_STEER_Q8 = 16'd20480;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_sample;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  command_kind;
        logic [18:0] speed_q8;
        logic [15:0] steer_q8;
        logic        last_command;
    } out_word_t;

    // Q16 sine of index*2*pi/1000, Q30 Taylor series up to x^15
    function automatic logic [SINE_W-1:0] sine_q16(input int unsigned idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        int unsigned        i;
        i   = (idx > 250) ? 250 : idx;
        x   = (64'(i) * TWO_PI_Q30 + 64'd500) / 64'd1000;
        x2  = (x * x) >> 30;
        t   = x;
        acc = $signed(x);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                acc = acc - $signed(t);
            end else begin
                acc = acc + $signed(t);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return SINE_W'((64'(acc) + 64'd8192) >> 14);
    endfunction

    typedef logic [SINE_W-1:0] sine_rom_t [LEFT_END];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < LEFT_END; i++) begin
            rom[i] = sine_q16(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- hw/rtl/lidar_sector_steering.sv -----
// lidar_sector_steering top level: running sector minima, jump/stop tracking
// and a three-stage command pipeline with a two-word output register.
// Depends on lss_pkg.
`default_nettype none

// One range sample is taken per clock while s_ready is high. Samples update
// the left/right minima in the cycle they are accepted. The sample that ends
// a scan launches a job into a three-register pipeline (job, products,
// output); its command words pass those registers in that order. A scan end
// gives one or two words, and the output register holds both, so a second
// scan end can follow; words leave one per cycle while m_ready is high, and
// when words back up, s_ready drops only while the job register is occupied.
module lidar_sector_steering (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire lss_pkg::in_word_t         s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output lss_pkg::out_word_t             m_data,
    input  wire                            cfg_wr_en,
    input  wire [lss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire [lss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lss_pkg::*;

    // configuration
    logic [10:0]        cruise_reg;
    logic [RANGE_W-1:0] near_reg;
    logic [9:0]         jump_lim_reg;
    logic [9:0]         count_lim_reg;

    // scan state
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RANGE_W-1:0] lmin_reg, lmin_next;
    logic [IDX_W-1:0]   lpos_reg, lpos_next;
    logic               lfound_reg, lfound_next;
    logic [RANGE_W-1:0] rmin_reg, rmin_next;
    logic               rfound_reg, rfound_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [9:0]         jcnt_reg, jcnt_next;
    logic               latch_reg, latch_next;

    // stage 1: job
    logic               j_valid_reg, j_valid_next;
    logic               j_left_reg, j_right_reg;
    logic [RANGE_W-1:0] j_lmin_reg;
    logic [LPOS_W-1:0]  j_lpos_reg;
    logic               j_ebig_reg;
    logic [9:0]         j_e_reg;

    // stage 2: products
    logic               p_valid_reg, p_valid_next;
    logic               p_left_reg, p_right_reg, p_ebig_reg;
    logic [32:0]        p_lprod_reg;
    logic [37:0]        p_sprod_reg, p_vprod_reg;

    // stage 3: output pair
    logic               o_valid_reg, o_valid_next;
    logic               o_two_reg, o_sel_reg, o_sel_next;
    out_word_t          o_w0_reg, o_w1_reg;

    logic s_acc, o_ready, p_ready, j_ready, j_load, p_load, o_load, m_acc;
    logic in_scan, hit_left, hit_right, jump_hit, found_end;
    logic [IDX_W-1:0]   pos_end;
    logic [RANGE_W-1:0] r;
    logic [RANGE_W-1:0] e_full;
    logic [18:0]        ns, nv;
    logic [33:0]        lx;
    logic [24:0]        lq;
    logic [31:0]        ld_prod;
    logic [13:0]        ld;
    logic [13:0]        ds, dv;
    out_word_t          w0_next, w1_next;

    assign r       = s_data.range_mm;
    assign m_acc   = m_valid && m_ready;
    assign o_ready = !o_valid_reg || (m_ready && (o_sel_reg || !o_two_reg));
    assign p_ready = !p_valid_reg || o_ready;
    assign j_ready = !j_valid_reg || p_ready;
    assign s_ready = j_ready;
    assign s_acc   = s_valid && s_ready;
    assign j_load  = s_acc && s_data.last_sample;
    assign p_load  = j_valid_reg && p_ready;
    assign o_load  = p_valid_reg && o_ready;

    assign m_valid = o_valid_reg;
    assign m_data  = o_sel_reg ? o_w1_reg : o_w0_reg;

    // sample update and scan end
    always_comb begin
        in_scan   = (idx_reg < IDX_W'(SCAN_POINTS)) && (r < near_reg);
        hit_left  = in_scan && (idx_reg >= IDX_W'(1)) && (idx_reg < IDX_W'(LEFT_END))
                    && (r < lmin_reg);
        hit_right = in_scan && (idx_reg > IDX_W'(RIGHT_AFTER)) && (r < rmin_reg);

        lmin_next   = hit_left ? r : lmin_reg;
        lpos_next   = hit_left ? idx_reg : lpos_reg;
        lfound_next = lfound_reg || hit_left;
        rmin_next   = hit_right ? r : rmin_reg;
        rfound_next = rfound_reg || hit_right;
        idx_next    = (idx_reg < IDX_W'(SCAN_POINTS)) ? idx_reg + IDX_W'(1) : idx_reg;

        found_end = lfound_next;
        pos_end   = lpos_next;
        jump_hit  = ($signed({2'b00, prev_reg}) - $signed({2'b00, pos_end}))
                    > $signed({2'b00, jump_lim_reg});
        jcnt_next = (found_end && jump_hit && (jcnt_reg != 10'd1023))
                    ? jcnt_reg + 10'd1 : jcnt_reg;
        prev_next  = found_end ? pos_end : prev_reg;
        latch_next = latch_reg || (jcnt_next > count_lim_reg);

        e_full = (rmin_next > RANGE_W'(100)) ? rmin_next - RANGE_W'(100) : '0;
    end

    // pipeline arithmetic
    always_comb begin
        ns = {j_e_reg, 9'd0} + 19'd17;
        nv = 19'(j_e_reg) * 19'd384 + 19'd17;

        lx      = {1'b0, p_lprod_reg} + 34'd1280;
        lq      = lx[33:9];
        ld_prod = lq[15:0] * 32'd52429;
        ld      = (lq >= 25'd64000) ? 14'd12800 : ld_prod[31:18];
        ds      = p_sprod_reg[37:24];
        dv      = p_vprod_reg[37:24];

        if (p_left_reg) begin
            w0_next.command_kind = CMD_LEFT;
            w0_next.speed_q8     = {cruise_reg, 8'd0};
            w0_next.steer_q8     = 16'(ld) + 16'd7680;
            w0_next.last_command = 1'b1;
        end else begin
            w0_next.command_kind = CMD_STOP;
            w0_next.speed_q8     = STOP_SPEED_Q8;
            w0_next.steer_q8     = STOP_STEER_Q8;
            w0_next.last_command = !p_right_reg;
        end
        w1_next.command_kind = CMD_RIGHT;
        w1_next.speed_q8     = p_ebig_reg ? STOP_SPEED_Q8 : 19'd391680 - 19'(dv);
        w1_next.steer_q8     = p_ebig_reg ? 16'd23040 : 16'd33280 - 16'(ds);
        w1_next.last_command = 1'b1;

        j_valid_next = j_load || (j_valid_reg && !p_ready);
        p_valid_next = p_load || (p_valid_reg && !o_ready);
        if (o_load) begin
            o_valid_next = 1'b1;
            o_sel_next   = 1'b0;
        end else if (m_acc && !o_sel_reg && o_two_reg) begin
            o_valid_next = 1'b1;
            o_sel_next   = 1'b1;
        end else begin
            o_valid_next = o_valid_reg && !m_acc;
            o_sel_next   = o_sel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_reg    <= 11'd1530;
            near_reg      <= RANGE_W'(800);
            jump_lim_reg  <= 10'd25;
            count_lim_reg <= 10'd60;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CRUISE_SPEED: cruise_reg    <= cfg_wdata[10:0];
                CFG_NEAR_LIMIT:   near_reg      <= cfg_wdata;
                CFG_JUMP_LIMIT:   jump_lim_reg  <= cfg_wdata[9:0];
                CFG_COUNT_LIMIT:  count_lim_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            lmin_reg   <= RANGE_W'(800);
            lpos_reg   <= '0;
            lfound_reg <= 1'b0;
            rmin_reg   <= RANGE_W'(800);
            rfound_reg <= 1'b0;
            prev_reg   <= IDX_W'(90);
            jcnt_reg   <= '0;
            latch_reg  <= 1'b0;
        end else if (j_load) begin
            idx_reg    <= '0;
            lmin_reg   <= near_reg;
            lpos_reg   <= '0;
            lfound_reg <= 1'b0;
            rmin_reg   <= near_reg;
            rfound_reg <= 1'b0;
            prev_reg   <= prev_next;
            jcnt_reg   <= jcnt_next;
            latch_reg  <= latch_next;
        end else if (s_acc) begin
            idx_reg    <= idx_next;
            lmin_reg   <= lmin_next;
            lpos_reg   <= lpos_next;
            lfound_reg <= lfound_next;
            rmin_reg   <= rmin_next;
            rfound_reg <= rfound_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_sel_reg   <= 1'b0;
        end else begin
            j_valid_reg <= j_valid_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
            o_sel_reg   <= o_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (j_load) begin
            j_left_reg  <= !latch_next && found_end;
            j_right_reg <= rfound_next && !found_end;
            j_lmin_reg  <= lmin_next;
            j_lpos_reg  <= pos_end[LPOS_W-1:0];
            j_ebig_reg  <= e_full >= RANGE_W'(700);
            j_e_reg     <= e_full[9:0];
        end
        if (p_load) begin
            p_left_reg  <= j_left_reg;
            p_right_reg <= j_right_reg;
            p_ebig_reg  <= j_ebig_reg;
            p_lprod_reg <= 33'(j_lmin_reg) * 33'(SINE_ROM[j_lpos_reg]);
            p_sprod_reg <= 38'(ns) * 38'd479350;
            p_vprod_reg <= 38'(nv) * 38'd479350;
        end
        if (o_load) begin
            o_two_reg <= p_right_reg;
            o_w0_reg  <= w0_next;
            o_w1_reg  <= w1_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/steer_cmd_checker.sv -----
// Command checker for lidar_sector_steering: tracks register writes, predicts
// the command words of every scan and compares them with the result channel.
// Depends on lss_pkg.
module steer_cmd_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    input  wire                            s_ready,
    input  lss_pkg::in_word_t              s_data,
    input  wire                            m_valid,
    input  wire                            m_ready,
    input  lss_pkg::out_word_t             m_data,
    input  wire                            cfg_wr_en,
    input  wire [lss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire [lss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import lss_pkg::*;

    out_word_t   pending_cmds[$];

    logic [10:0] cruise;
    logic [15:0] near;
    logic [9:0]  jump_lim;
    logic [9:0]  count_lim;

    logic [9:0]  scan_idx;
    logic [15:0] left_min;
    logic [9:0]  left_pos;
    logic        left_seen;
    logic [15:0] right_min;
    logic        right_seen;
    logic [9:0]  prev_left_pos;
    logic [9:0]  jump_events;
    logic        stop_hold;

    // Q16 sine of i*2*pi/1000 from a Q30 Taylor series up to x^15
    function automatic longint unsigned bearing_sine(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          acc;
        x   = (longint'(i) * TWO_PI_Q30 + 500) / 1000;
        x2  = (x * x) >> 30;
        t   = x;
        acc = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return (longint'(acc) + 8192) >> 14;
    endfunction

    task automatic clear_scan();
        scan_idx   = '0;
        left_min   = near;
        left_pos   = '0;
        left_seen  = 1'b0;
        right_min  = near;
        right_seen = 1'b0;
    endtask

    task automatic predict_sample(input in_word_t w);
        out_word_t       cmd;
        longint unsigned p;
        longint unsigned d;
        longint unsigned e;
        longint unsigned ds;
        longint unsigned dv;
        logic            right_cmd;
        if (scan_idx < SCAN_POINTS && w.range_mm < near) begin
            if (scan_idx >= 1 && scan_idx < LEFT_END && w.range_mm < left_min) begin
                left_min  = w.range_mm;
                left_pos  = scan_idx;
                left_seen = 1'b1;
            end
            if (scan_idx > RIGHT_AFTER && w.range_mm < right_min) begin
                right_min  = w.range_mm;
                right_seen = 1'b1;
            end
        end
        if (scan_idx < SCAN_POINTS) begin
            scan_idx = scan_idx + 1'b1;
        end
        if (!w.last_sample) begin
            return;
        end

        if (left_seen) begin
            if (int'(prev_left_pos) - int'(left_pos) > int'(jump_lim)
                    && jump_events < 10'd1023) begin
                jump_events = jump_events + 1'b1;
            end
            prev_left_pos = left_pos;
        end
        if (jump_events > count_lim) begin
            stop_hold = 1'b1;
        end

        if (!stop_hold && left_seen) begin
            p = longint'(left_min) * bearing_sine(left_pos);
            d = (p + 1280) / 2560;
            if (d > 12800) begin
                d = 12800;
            end
            cmd.command_kind = CMD_LEFT;
            cmd.speed_q8     = {cruise, 8'd0};
            cmd.steer_q8     = 16'(d + 7680);
            cmd.last_command = 1'b1;
            pending_cmds.push_back(cmd);
        end else begin
            right_cmd        = right_seen && !left_seen;
            cmd.command_kind = CMD_STOP;
            cmd.speed_q8     = STOP_SPEED_Q8;
            cmd.steer_q8     = STOP_STEER_Q8;
            cmd.last_command = !right_cmd;
            pending_cmds.push_back(cmd);
            if (right_cmd) begin
                e  = (right_min > 100) ? longint'(right_min - 16'd100) : 0;
                ds = (e * 512 + 17) / 35;
                dv = (e * 384 + 17) / 35;
                cmd.command_kind = CMD_RIGHT;
                cmd.steer_q8     = (ds >= 10240) ? 16'd23040 : 16'(33280 - ds);
                cmd.speed_q8     = (dv >= 7680) ? 19'd384000 : 19'(391680 - dv);
                cmd.last_command = 1'b1;
                pending_cmds.push_back(cmd);
            end
        end
        clear_scan();
    endtask

    always @(posedge aclk) begin
        out_word_t exp_cmd;
        if (!aresetn) begin
            cruise        = 11'd1530;
            near          = 16'd800;
            jump_lim      = 10'd25;
            count_lim     = 10'd60;
            clear_scan();
            prev_left_pos = 10'd90;
            jump_events   = '0;
            stop_hold     = 1'b0;
            pending_cmds.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_cmds.size() == 0) begin
                    $error("command word with nothing expected: kind %0d speed %0d steer %0d",
                           m_data.command_kind, m_data.speed_q8, m_data.steer_q8);
                    mismatches++;
                end else begin
                    exp_cmd = pending_cmds.pop_front();
                    if (m_data.command_kind !== exp_cmd.command_kind) begin
                        $error("command_kind: expected %0d, actual %0d",
                               exp_cmd.command_kind, m_data.command_kind);
                        mismatches++;
                    end
                    if (m_data.speed_q8 !== exp_cmd.speed_q8) begin
                        $error("speed_q8: expected %0d, actual %0d",
                               exp_cmd.speed_q8, m_data.speed_q8);
                        mismatches++;
                    end
                    if (m_data.steer_q8 !== exp_cmd.steer_q8) begin
                        $error("steer_q8: expected %0d, actual %0d",
                               exp_cmd.steer_q8, m_data.steer_q8);
                        mismatches++;
                    end
                    if (m_data.last_command !== exp_cmd.last_command) begin
                        $error("last_command: expected %0d, actual %0d",
                               exp_cmd.last_command, m_data.last_command);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_CRUISE_SPEED: cruise    = cfg_wdata[10:0];
                    CFG_NEAR_LIMIT:   near      = cfg_wdata;
                    CFG_JUMP_LIMIT:   jump_lim  = cfg_wdata[9:0];
                    CFG_COUNT_LIMIT:  count_lim = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_sample(s_data);
            end
        end
        outstanding <= pending_cmds.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for lidar_sector_steering: clock, reset, register phases,
// sample stimulus and output back-pressure; verdict from steer_cmd_checker.
// Depends on lss_pkg, lidar_sector_steering and steer_cmd_checker.
module tb;
    import lss_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SCANS_PER_PHASE = 3;
    localparam int LONG_PHASE = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          cycles     = 0;
    int          ready_hold = 0;
    logic [15:0] cur_near   = 16'd800;

    lidar_sector_steering DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    steer_cmd_checker cmd_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // result-side stalls: mostly short, now and then long
    always @(negedge aclk) begin
        int k;
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else begin
            k = $urandom_range(0, 99);
            if (k < 55) begin
                m_ready <= 1'b1;
                ready_hold = $urandom_range(1, 30);
            end else if (k < 90) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else if (k < 97) begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(3, 10);
            end else begin
                m_ready <= 1'b0;
                ready_hold = $urandom_range(20, 60);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [15:0] r, input logic last);
        s_valid <= 1'b1;
        s_data  <= '{range_mm: r, last_sample: last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_regs(input int cruise, input int near, input int jump, input int count);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_CRUISE_SPEED;
        cfg_wdata <= 16'(cruise);
        @(negedge aclk);
        cfg_addr  <= CFG_NEAR_LIMIT;
        cfg_wdata <= 16'(near);
        @(negedge aclk);
        cfg_addr  <= CFG_JUMP_LIMIT;
        cfg_wdata <= 16'(jump);
        @(negedge aclk);
        cfg_addr  <= CFG_COUNT_LIMIT;
        cfg_wdata <= 16'(count);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_near  = 16'(near);
    endtask

    initial begin
        int          k;
        int          len;
        int          gap;
        int          cruise;
        int          near;
        int          jump;
        int          count;
        logic        quiet;
        logic        long_scan;
        logic [15:0] r;
        logic [15:0] last_r;

        last_r = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: lone sample at index zero, left hit at index one,
        // equal ranges and the near limit itself, no-return scans
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b1);
        send_sample(16'd5, 1'b0);
        send_sample(16'd799, 1'b0);
        send_sample(16'd800, 1'b0);
        send_sample(16'd799, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        drain();
        write_regs(1600, 65535, 25, 1023);
        send_sample(16'd7, 1'b1);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd65533, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                cruise = 1500; near = 1; jump = 0; count = 1023;
            end else if (p == 1) begin
                cruise = 1600; near = 65535; jump = 1023; count = 1023;
            end else if (p == 7) begin
                // last phase latches the stop
                cruise = $urandom_range(1500, 1600); near = 1200; jump = 0; count = 0;
            end else begin
                cruise = $urandom_range(1500, 1600);
                k = $urandom_range(0, 99);
                near = (k < 70) ? $urandom_range(200, 2000) :
                       (k < 90) ? $urandom_range(1, 65535) : 65535;
                jump = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 1023);
                count = $urandom_range(200, 1023);
            end
            write_regs(cruise, near, jump, count);

            for (int s = 0; s < SCANS_PER_PHASE; s++) begin
                // one full-length scan runs past the index limit with a clear
                // left sector, so the right command is taken
                long_scan = (p == LONG_PHASE) && (s == 0);
                k = $urandom_range(0, 99);
                if (long_scan)   len = $urandom_range(1001, 1012);
                else if (k < 25) len = $urandom_range(1, 3);
                else if (k < 85) len = $urandom_range(4, 40);
                else             len = $urandom_range(41, 215);
                quiet = ($urandom_range(0, 99) < 30);

                for (int i = 0; i < len; i++) begin
                    if (long_scan) begin
                        if (i < LEFT_END || $urandom_range(0, 99) >= 3) begin
                            r = 16'hFFFF;
                        end else begin
                            r = 16'($urandom_range(0, int'(cur_near) - 1));
                        end
                    end else begin
                        k = $urandom_range(0, 99);
                        if (k < 15)      r = 16'hFFFF;
                        else if (k < 30) r = 16'($urandom);
                        else if (k < 42) r = last_r;
                        else if (k < 52) r = 16'($urandom_range(0, 3));
                        else if (k < 60) r = 16'(int'(cur_near) - 1 + $urandom_range(0, 2));
                        else if (k < 66) r = 16'($urandom_range(80, 120));
                        else             r = 16'($urandom_range(0, int'(cur_near) - 1));
                    end
                    last_r = r;
                    send_sample(r, i == len - 1);

                    if (quiet) begin
                        gap = 0;
                    end else begin
                        k = $urandom_range(0, 99);
                        if (k < 70)      gap = 0;
                        else if (k < 92) gap = $urandom_range(1, 3);
                        else if (k < 98) gap = $urandom_range(4, 10);
                        else             gap = $urandom_range(20, 40);
                    end
                    if (gap > 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end

                if ($urandom_range(0, 99) < 10) begin
                    drain();
                end
            end
            drain();
        end

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lss_pkg.sv
hw/rtl/lidar_sector_steering.sv
tb/sv/steer_cmd_checker.sv
tb/sv/tb.sv
